### rtl/pol_pkg.sv
package pol_pkg;

  // List capacity and the widths that follow from it.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Fixed widths of the transfer fields.
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

endpackage

### rtl/positional_ordered_list.sv
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  -------------------------------------------
// in       sink       in_valid_i/in_stall_o   cmd_i, position_i, value_i
// out      source     out_valid_o/out_stall_i ok_o, data_out_o, found_at_o, list_length_o
//
// A refused command ends without a write to the entry store. Insert and remove move each
// shifted entry with a read and then a write, and search compares the entries one at a time,
// since the entry store has a single read and a single write port.
// Reset clears the fill count and the control state; entries are not cleared.
// The input is stalled while a command is in progress or a result waits for transfer.
module positional_ordered_list (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [pol_pkg::CMD_W-1:0]     cmd_i,
  input  logic        [pol_pkg::POS_W-1:0]     position_i,
  input  logic signed [pol_pkg::DATA_W-1:0]    value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 ok_o,
  output logic signed [pol_pkg::DATA_W-1:0]    data_out_o,
  output logic        [pol_pkg::POS_W-1:0]     found_at_o,
  output logic        [pol_pkg::LEN_W-1:0]     list_length_o
);

  localparam int unsigned IDX_W  = pol_pkg::IDX_W;
  localparam int unsigned CNT_W  = pol_pkg::CNT_W;
  localparam int unsigned POS_W  = pol_pkg::POS_W;
  localparam int unsigned DATA_W = pol_pkg::DATA_W;
  localparam int unsigned LEN_W  = pol_pkg::LEN_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_RD   = 4'd1;
  localparam logic [3:0] S_INS_WR   = 4'd2;
  localparam logic [3:0] S_REM_CAP  = 4'd3;
  localparam logic [3:0] S_REM_RD   = 4'd4;
  localparam logic [3:0] S_REM_WR   = 4'd5;
  localparam logic [3:0] S_RD_WAIT  = 4'd6;
  localparam logic [3:0] S_SRCH_RD  = 4'd7;
  localparam logic [3:0] S_SRCH_CMP = 4'd8;

  logic [3:0]               state_q, state_d;
  logic [IDX_W-1:0]         ptr_q, ptr_d;
  logic [IDX_W-1:0]         pos_q, pos_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic                     out_valid_q, out_valid_d;
  logic                     ok_q, ok_d;
  logic signed [DATA_W-1:0] data_q, data_d;
  logic [POS_W-1:0]         found_q, found_d;

  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [IDX_W-1:0]         mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata_q;
  logic signed [DATA_W-1:0] mem_q [pol_pkg::DEPTH];

  logic                     in_fire;
  logic [POS_W-1:0]         pos_m1;
  logic [CNT_W-1:0]         ptr_inc;
  logic                     pos_above_count;
  logic                     list_full;

  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign pos_m1          = position_i - POS_W'(1);
  assign ptr_inc         = CNT_W'(ptr_q) + CNT_W'(1);
  assign pos_above_count = {{CNT_W{1'b0}}, position_i} > {{POS_W{1'b0}}, count_q};
  assign list_full       = count_q >= CNT_W'(pol_pkg::DEPTH);

  // Entry store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    count_d     = count_q;
    value_d     = value_q;
    out_valid_d = out_valid_q;
    ok_d        = ok_q;
    data_d      = data_q;
    found_d     = found_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = mem_rdata_q;
    mem_raddr   = ptr_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        // Reads of the addressed entry start at once; the data is ignored if unused.
        mem_raddr = pos_m1[IDX_W-1:0];
        if (in_fire) begin
          value_d = value_i;
          ok_d    = 1'b0;
          data_d  = '0;
          found_d = '0;
          case (cmd_i)
            pol_pkg::CMD_INSERT: begin
              if (pos_above_count || list_full) begin
                out_valid_d = 1'b1;
              end else begin
                ptr_d   = count_q[IDX_W-1:0];
                pos_d   = position_i[IDX_W-1:0];
                state_d = S_INS_RD;
              end
            end
            pol_pkg::CMD_REMOVE: begin
              if ((position_i == '0) || pos_above_count) begin
                out_valid_d = 1'b1;
              end else begin
                ptr_d   = pos_m1[IDX_W-1:0];
                state_d = S_REM_CAP;
              end
            end
            pol_pkg::CMD_READ: begin
              if ((position_i == '0) || pos_above_count) begin
                data_d      = '1;
                out_valid_d = 1'b1;
              end else begin
                state_d = S_RD_WAIT;
              end
            end
            default: begin
              ptr_d = '0;
              if (count_q == '0) begin
                out_valid_d = 1'b1;
              end else begin
                state_d = S_SRCH_RD;
              end
            end
          endcase
        end
      end

      // Insert walks from the tail down, moving each entry one place up.
      S_INS_RD: begin
        if (ptr_q == pos_q) begin
          mem_we      = 1'b1;
          mem_waddr   = pos_q;
          mem_wdata   = value_q;
          count_d     = count_q + CNT_W'(1);
          ok_d        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          mem_raddr = ptr_q - IDX_W'(1);
          state_d   = S_INS_WR;
        end
      end

      S_INS_WR: begin
        mem_we  = 1'b1;
        ptr_d   = ptr_q - IDX_W'(1);
        state_d = S_INS_RD;
      end

      S_REM_CAP: begin
        data_d  = mem_rdata_q;
        state_d = S_REM_RD;
      end

      // Remove walks from the gap up, moving each later entry one place down.
      S_REM_RD: begin
        if (ptr_inc < count_q) begin
          mem_raddr = ptr_inc[IDX_W-1:0];
          state_d   = S_REM_WR;
        end else begin
          count_d     = count_q - CNT_W'(1);
          ok_d        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_REM_WR: begin
        mem_we  = 1'b1;
        ptr_d   = ptr_inc[IDX_W-1:0];
        state_d = S_REM_RD;
      end

      S_RD_WAIT: begin
        data_d      = mem_rdata_q;
        ok_d        = 1'b1;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      S_SRCH_RD: begin
        state_d = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        if (mem_rdata_q == value_q) begin
          ok_d        = 1'b1;
          found_d     = POS_W'(ptr_inc);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (ptr_inc >= count_q) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          ptr_d   = ptr_inc[IDX_W-1:0];
          state_d = S_SRCH_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    pos_q   <= pos_d;
    value_q <= value_d;
    ok_q    <= ok_d;
    data_q  <= data_d;
    found_q <= found_d;
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign data_out_o    = data_q;
  assign found_at_o    = found_q;
  assign list_length_o = LEN_W'(count_q);

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(pol_pkg::DEPTH))
    else $error("fill count beyond capacity");

  // A waiting result only ever sits beside an idle sequencer.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_IDLE))
    else $error("result pending while a command is in progress");

  // Writes never land beyond the slot just past the current tail.
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CNT_W'(mem_waddr) <= count_q))
    else $error("entry write outside the list");

  // The length changes only together with a newly presented result.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $rose(out_valid_q))
    else $error("fill count changed without a result");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 2 * pol_pkg::DEPTH + 8;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned HOLD_OFF       = 300;

  typedef struct packed {
    logic                              ok;
    logic signed [pol_pkg::DATA_W-1:0] data;
    logic        [pol_pkg::POS_W-1:0]  at;
    logic        [pol_pkg::LEN_W-1:0]  len;
  } reply_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic        [pol_pkg::CMD_W-1:0]  cmd_i;
  logic        [pol_pkg::POS_W-1:0]  position_i;
  logic signed [pol_pkg::DATA_W-1:0] value_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic                              ok_o;
  logic signed [pol_pkg::DATA_W-1:0] data_out_o;
  logic        [pol_pkg::POS_W-1:0]  found_at_o;
  logic        [pol_pkg::LEN_W-1:0]  list_length_o;

  // Shadow copy of the list, updated as each command is accepted.
  logic signed [pol_pkg::DATA_W-1:0] list_entries [pol_pkg::DEPTH];
  int unsigned                       list_count;
  reply_t                            awaited_replies [$];

  int unsigned fail_count = 0;
  int unsigned tx_idle_pct = 25;
  int unsigned rx_idle_pct = 25;
  int unsigned hold_left = 0;
  bit          growing = 1'b1;

  positional_ordered_list uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_o          (ok_o),
    .data_out_o    (data_out_o),
    .found_at_o    (found_at_o),
    .list_length_o (list_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic reply_t apply_list_command(pol_pkg::cmd_e c,
                                                logic [pol_pkg::POS_W-1:0] p,
                                                logic signed [pol_pkg::DATA_W-1:0] v);
    reply_t      r;
    int unsigned idx;
    r = '0;
    case (c)
      pol_pkg::CMD_INSERT: begin
        if (p <= list_count && list_count < pol_pkg::DEPTH) begin
          for (idx = list_count; idx > p; idx--) list_entries[idx] = list_entries[idx-1];
          list_entries[p] = v;
          list_count++;
          r.ok = 1'b1;
        end
      end
      pol_pkg::CMD_REMOVE: begin
        if (p != 0 && p <= list_count) begin
          r.data = list_entries[p-1];
          for (idx = p - 1; idx + 1 < list_count; idx++) list_entries[idx] = list_entries[idx+1];
          list_count--;
          r.ok = 1'b1;
        end
      end
      pol_pkg::CMD_READ: begin
        if (p != 0 && p <= list_count) begin
          r.data = list_entries[p-1];
          r.ok   = 1'b1;
        end else begin
          r.data = -1;
        end
      end
      default: begin
        for (idx = 0; idx < list_count; idx++) begin
          if (r.at == 0 && list_entries[idx] == v) r.at = pol_pkg::POS_W'(idx + 1);
        end
        r.ok = (r.at != 0);
      end
    endcase
    r.len = pol_pkg::LEN_W'(list_count);
    return r;
  endfunction

  // Small pool so that duplicates and search hits are common, plus the extremes.
  function automatic logic signed [pol_pkg::DATA_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return int'($urandom_range(0, 7)) - 4;
    if (roll < 40) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_command(pol_pkg::cmd_e c, int unsigned p,
                              logic signed [pol_pkg::DATA_W-1:0] v);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    position_i <= pol_pkg::POS_W'(p);
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    awaited_replies.push_back(apply_list_command(c, pol_pkg::POS_W'(p), v));
    @(negedge clk_i);
  endtask

  task automatic check_reply();
    reply_t got;
    reply_t want;
    got = {ok_o, data_out_o, found_at_o, list_length_o};
    if (awaited_replies.size() == 0) begin
      note_failure($sformatf("unexpected result ok=%0b data=%0d at=%0d len=%0d",
                             got.ok, got.data, got.at, got.len));
    end else begin
      want = awaited_replies.pop_front();
      if (got !== want)
        note_failure($sformatf({"mismatch: expected ok=%0b data=%0d at=%0d len=%0d,",
                                " got ok=%0b data=%0d at=%0d len=%0d"},
                               want.ok, want.data, want.at, want.len,
                               got.ok, got.data, got.at, got.len));
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_reply();
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL positional_ordered_list");
    $finish;
  end

  task automatic run_random_items(int unsigned n);
    int unsigned                       k;
    int unsigned                       roll;
    int unsigned                       ins_w;
    int unsigned                       rem_w;
    int unsigned                       p;
    pol_pkg::cmd_e                     c;
    logic signed [pol_pkg::DATA_W-1:0] v;
    for (k = 0; k < n; k++) begin
      // Sweep the fill level between empty and full.
      if (list_count == pol_pkg::DEPTH) growing = 1'b0;
      else if (list_count == 0) growing = 1'b1;
      ins_w = growing ? 45 : 15;
      rem_w = growing ? 15 : 45;
      roll  = $urandom_range(0, 99);
      if (roll < ins_w) c = pol_pkg::CMD_INSERT;
      else if (roll < ins_w + rem_w) c = pol_pkg::CMD_REMOVE;
      else if (roll < ins_w + rem_w + 20) c = pol_pkg::CMD_READ;
      else c = pol_pkg::CMD_SEARCH;

      if ($urandom_range(0, 9) == 0) p = $urandom_range(0, pol_pkg::DEPTH);
      else if (c == pol_pkg::CMD_INSERT) p = $urandom_range(0, list_count);
      else if (list_count != 0) p = $urandom_range(1, list_count);
      else p = $urandom_range(0, pol_pkg::DEPTH);

      if (c == pol_pkg::CMD_SEARCH && list_count != 0 && $urandom_range(0, 9) < 6)
        v = list_entries[$urandom_range(0, list_count - 1)];
      else
        v = pick_value();
      send_command(c, p, v);
    end
  endtask

  task automatic test_empty_list();
    send_command(pol_pkg::CMD_READ, 1, 0);
    send_command(pol_pkg::CMD_REMOVE, 0, 0);
    send_command(pol_pkg::CMD_INSERT, 1, 5);
    send_command(pol_pkg::CMD_SEARCH, 0, 0);
  endtask

  task automatic test_fill_to_capacity();
    int unsigned k;
    send_command(pol_pkg::CMD_INSERT, 0, 32'sh7fff_ffff);
    send_command(pol_pkg::CMD_INSERT, 1, 32'sh8000_0000);
    send_command(pol_pkg::CMD_INSERT, 0, -1);
    for (k = 3; k < pol_pkg::DEPTH; k++)
      send_command(pol_pkg::CMD_INSERT, (k == pol_pkg::DEPTH - 1) ? k : k / 2,
                   (k == 9) ? -1 : 100 + k);
    // The list is full now, so even a valid position is refused.
    send_command(pol_pkg::CMD_INSERT, pol_pkg::DEPTH, 7);
  endtask

  task automatic test_full_list();
    send_command(pol_pkg::CMD_READ, pol_pkg::DEPTH, 0);
    send_command(pol_pkg::CMD_READ, 0, 0);
    send_command(pol_pkg::CMD_SEARCH, 0, -1);
    send_command(pol_pkg::CMD_REMOVE, pol_pkg::DEPTH, 0);
    send_command(pol_pkg::CMD_REMOVE, 1, 0);
    send_command(pol_pkg::CMD_REMOVE, pol_pkg::DEPTH - 1, 0);
  endtask

  task automatic test_no_idling();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_items(150);
    tx_idle_pct = 25;
    rx_idle_pct = 25;
  endtask

  task automatic test_random_traffic();
    run_random_items(600);
  endtask

  // The receiver holds off while commands keep coming, so the input stalls.
  task automatic test_output_hold_off();
    hold_left = HOLD_OFF;
    run_random_items(20);
  endtask

  task automatic test_pause_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaited_replies.size() != 0);
    run_random_items(150);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    cmd_i      = pol_pkg::CMD_INSERT;
    position_i = '0;
    value_i    = '0;
    list_count = 0;
    foreach (list_entries[i]) list_entries[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_fill_to_capacity();
    test_full_list();
    test_no_idling();
    test_random_traffic();
    test_output_hold_off();
    test_pause_until_drained();

    in_valid_i <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    fail_count += awaited_replies.size();
    if (fail_count == 0) $display("PASS positional_ordered_list");
    else $display("FAIL positional_ordered_list");
    $finish;
  end

endmodule

### filelist.f
rtl/pol_pkg.sv
rtl/positional_ordered_list.sv
verif/tb.sv
